// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the semaphore table RTL.
// Needs nothing else; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("semaphore table assertion failed");
`define STS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("semaphore table assertion failed");
`else
`define STS_ASSERT(lbl, clk, rst_n, prop)
`define STS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/sts_pkg.sv =====
// Package for the semaphore table: defaults, field codes and the
// command and status structs between controller and datapath.
`default_nettype none
package sts_pkg;

  localparam int TableEntriesDef = 16;
  localparam int CountBitsDef    = 16;
  localparam int KeyBits         = 28;

  localparam logic [1:0] MODE_SIGNAL  = 2'd0;
  localparam logic [1:0] MODE_CONSUME = 2'd1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_SATURATED = 3'd3;
  localparam logic [2:0] STAT_MASKED    = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } sts_cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sts_ctrl.sv =====
// Controller state machine of the semaphore table: idle, scan, drain, commit.
// Depends on sts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sts_ctrl
  import sts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  output sts_cmd_t       cmd_o,
  input  wire sts_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && start_i;
  assign cmd_o.step    = (state_q == ST_SCAN);
  assign cmd_o.commit  = (state_q == ST_COMMIT);

  `STS_ASSERT(a_commit_to_idle, clk_i, rst_ni, cmd_o.commit |=> !busy_o)
  `STS_ASSERT(a_load_to_scan, clk_i, rst_ni, cmd_o.load |=> (state_q == ST_SCAN))
  `STS_ASSERT(a_drain_after_scan, clk_i, rst_ni,
              (state_q == ST_DRAIN) |-> ($past(state_q) == ST_SCAN))

endmodule
`default_nettype wire

// ===== hw/rtl/sts_datapath.sv =====
// Datapath of the semaphore table: request and config registers, entry
// memory with valid bits, scan compare and the commit update. Uses sts_pkg.
`default_nettype none
`include "assert_macros.svh"
module sts_datapath
  import sts_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int COUNT_BITS    = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sts_cmd_t    cmd_i,
  output sts_stat_t        stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  src_endpoint_i,
  input  wire logic [7:0]  dst_endpoint_i,
  input  wire logic [7:0]  sync_number_i,
  input  wire logic [3:0]  peer_npu_i,
  input  wire logic        use_mask_i,
  input  wire logic [31:0] npu_select_mask_i,
  output logic             done_o,
  output logic             ready_res_o,
  output logic [2:0]       status_o,
  output logic [15:0]      count_after_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [KeyBits-1:0]    key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [4:0]         own_id_q;
  logic [1:0]         mode_q;
  logic [KeyBits-1:0] key_q;
  logic               use_mask_q;
  logic [31:0]        mask_q;

  logic [IdxW-1:0]       addr_q, rd_idx_q, hit_idx_q, free_idx_q;
  logic                  rd_pend_q, hit_q, free_q;
  logic [KeyBits-1:0]    rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q, hit_cnt_q;

  logic                  done_q, res_ready_q;
  logic [2:0]            res_status_q;
  logic [15:0]           res_cnt_q;

  logic                  masked, ready_c, wr_en, set_valid, clr_valid;
  logic [2:0]            status_c;
  logic [COUNT_BITS-1:0] cnt_c;
  logic [IdxW-1:0]       wr_idx;
  logic [31:0]           cnt_ext;

  assign stat_o.scan_last = (addr_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_we_i) begin
      own_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      key_q      <= {src_endpoint_i, dst_endpoint_i, sync_number_i, peer_npu_i};
      use_mask_q <= use_mask_i;
      mask_q     <= npu_select_mask_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_key_q <= key_mem[addr_q];
      rd_cnt_q <= cnt_mem[addr_q];
      rd_idx_q <= addr_q;
    end
    if (wr_en) begin
      key_mem[wr_idx] <= key_q;
      cnt_mem[wr_idx] <= cnt_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.step;
      if (cmd_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.step) addr_q <= addr_q + 1'b1;
        if (rd_pend_q) begin
          if (!hit_q && valid_q[rd_idx_q] && (rd_key_q == key_q)) hit_q <= 1'b1;
          if (!free_q && !valid_q[rd_idx_q]) free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q && !hit_q && valid_q[rd_idx_q] && (rd_key_q == key_q)) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= rd_cnt_q;
    end
    if (rd_pend_q && !free_q && !valid_q[rd_idx_q]) begin
      free_idx_q <= rd_idx_q;
    end
  end

  always_comb begin
    masked    = use_mask_q && !mask_q[own_id_q];
    cnt_c     = hit_q ? hit_cnt_q : '0;
    ready_c   = 1'b0;
    status_c  = STAT_OK;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_idx    = hit_idx_q;
    if (masked) begin
      ready_c  = 1'b1;
      status_c = STAT_MASKED;
    end else if (mode_q == MODE_SIGNAL) begin
      if (!hit_q) begin
        if (!free_q) begin
          status_c = STAT_FULL;
        end else begin
          cnt_c     = COUNT_BITS'(1);
          ready_c   = 1'b1;
          wr_en     = cmd_i.commit;
          set_valid = cmd_i.commit;
          wr_idx    = free_idx_q;
        end
      end else if (hit_cnt_q == CountMax) begin
        ready_c  = 1'b1;
        status_c = STAT_SATURATED;
      end else begin
        cnt_c   = hit_cnt_q + COUNT_BITS'(1);
        ready_c = 1'b1;
        wr_en   = cmd_i.commit;
      end
    end else if (mode_q == MODE_CONSUME) begin
      if (!hit_q) begin
        status_c = STAT_EMPTY;
      end else begin
        cnt_c     = hit_cnt_q - COUNT_BITS'(1);
        ready_c   = 1'b1;
        wr_en     = cmd_i.commit;
        clr_valid = cmd_i.commit && (cnt_c == '0);
      end
    end else begin
      if (!hit_q) begin
        status_c = STAT_EMPTY;
      end else begin
        ready_c = 1'b1;
      end
    end
    cnt_ext = 32'(cnt_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (set_valid) valid_q[wr_idx] <= 1'b1;
      if (clr_valid) valid_q[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_ready_q  <= ready_c;
      res_status_q <= status_c;
      res_cnt_q    <= cnt_ext[15:0];
    end
  end

  assign done_o        = done_q;
  assign ready_res_o   = res_ready_q;
  assign status_o      = res_status_q;
  assign count_after_o = res_cnt_q;

  `STS_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `STS_ASSERT(a_hit_still_valid, clk_i, rst_ni,
              (cmd_i.commit && hit_q) |-> valid_q[hit_idx_q])

endmodule
`default_nettype wire

// ===== hw/rtl/sync_token_semaphore_table.sv =====
// Table of counting semaphores keyed by endpoints, sync id and peer NPU.
// One request runs through a scan of the entry memory, one entry per cycle
// through its single read port, then a drain and a commit state; done_o is
// registered from the commit state, and start is taken again while it is high.
// The receiver cannot stall. Reset clears all valid bits and own_npu_id at once.
`default_nettype none
module sync_token_semaphore_table
  import sts_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int COUNT_BITS    = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  src_endpoint_i,
  input  wire logic [7:0]  dst_endpoint_i,
  input  wire logic [7:0]  sync_number_i,
  input  wire logic [3:0]  peer_npu_i,
  input  wire logic        use_mask_i,
  input  wire logic [31:0] npu_select_mask_i,
  output logic             done_o,
  output logic             ready_res_o,
  output logic [2:0]       status_o,
  output logic [15:0]      count_after_o
);

  sts_cmd_t  cmd;
  sts_stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  sts_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .src_endpoint_i   (src_endpoint_i),
    .dst_endpoint_i   (dst_endpoint_i),
    .sync_number_i    (sync_number_i),
    .peer_npu_i       (peer_npu_i),
    .use_mask_i       (use_mask_i),
    .npu_select_mask_i(npu_select_mask_i),
    .done_o           (done_o),
    .ready_res_o      (ready_res_o),
    .status_o         (status_o),
    .count_after_o    (count_after_o)
  );

endmodule
`default_nettype wire

// ===== dv/sync_token_semaphore_table_test.sv =====
// Testbench for sync_token_semaphore_table: directed and random request beats
// checked against a behavioral model of the semaphore table kept in this file.
// Depends on sts_pkg and the sync_token_semaphore_table RTL only.
`default_nettype none
module sync_token_semaphore_table_test
  import sts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableEntries = TableEntriesDef;
  localparam int CountBits = CountBitsDef;
  localparam int unsigned CountMax = (32'd1 << CountBits) - 1;
  localparam int HalfPeriod = 2;
  localparam int ResetCycles = 8;
  localparam int SettleCycles = TableEntries + 8;
  localparam int PoolSize = 20;
  localparam int PrintLimit = 40;
  localparam int LimitNs = 2_000_000;

  localparam logic [1:0] ModeQuery = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] sync_id;
    logic [3:0] peer;
  } sem_key_t;

  typedef struct packed {
    logic [1:0]  mode;
    sem_key_t    key;
    logic        use_mask;
    logic [31:0] sel_bits;
  } sem_req_t;

  typedef struct packed {
    logic        ready;
    logic [2:0]  status;
    logic [15:0] count;
  } sem_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_start = 1'b0;
  logic        blk_busy;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic [1:0]  mode_i = '0;
  logic [7:0]  src_endpoint_i = '0;
  logic [7:0]  dst_endpoint_i = '0;
  logic [7:0]  sync_number_i = '0;
  logic [3:0]  peer_npu_i = '0;
  logic        use_mask_i = 1'b0;
  logic [31:0] npu_select_mask_i = '0;
  logic        done_o;
  logic        ready_res_o;
  logic [2:0]  status_o;
  logic [15:0] count_after_o;

  sync_token_semaphore_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (req_start),
    .busy              (blk_busy),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .src_endpoint_i    (src_endpoint_i),
    .dst_endpoint_i    (dst_endpoint_i),
    .sync_number_i     (sync_number_i),
    .peer_npu_i        (peer_npu_i),
    .use_mask_i        (use_mask_i),
    .npu_select_mask_i (npu_select_mask_i),
    .done_o            (done_o),
    .ready_res_o       (ready_res_o),
    .status_o          (status_o),
    .count_after_o     (count_after_o)
  );

  always begin
    #HalfPeriod;
    clk_i = ~clk_i;
  end

  // Model state of the semaphore table.
  logic        slot_live [TableEntries] = '{default: 1'b0};
  sem_key_t    slot_key [TableEntries] = '{default: '0};
  int unsigned slot_count [TableEntries] = '{default: 0};
  logic [4:0]  own_npu_id = '0;

  sem_req_t    request_backlog[$];
  sem_result_t predicted_outcomes[$];
  sem_req_t    active_req = '0;
  sem_key_t    key_pool [PoolSize];
  int          gap_left = 0;
  bit          steady_flow = 1'b0;
  int          requests_issued = 0;
  int          outcomes_seen = 0;
  int          mismatch_count = 0;

  function automatic sem_result_t apply_request(input sem_req_t r);
    int hit;
    int slot;
    int i;
    int unsigned cur;
    sem_result_t res;
    hit = -1;
    slot = -1;
    for (i = TableEntries - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_key[i] == r.key && slot_count[i] != 0) hit = i;
      if (!slot_live[i] || slot_count[i] == 0) slot = i;
    end
    cur = (hit >= 0) ? slot_count[hit] : 0;
    res.ready = 1'b0;
    res.status = STAT_OK;
    if (r.use_mask && !r.sel_bits[own_npu_id]) begin
      res.ready = 1'b1;
      res.status = STAT_MASKED;
    end else if (r.mode == MODE_SIGNAL) begin
      if (hit < 0) begin
        if (slot < 0) begin
          res.status = STAT_FULL;
          cur = 0;
        end else begin
          slot_live[slot] = 1'b1;
          slot_key[slot] = r.key;
          slot_count[slot] = 1;
          cur = 1;
          res.ready = 1'b1;
        end
      end else if (cur >= CountMax) begin
        cur = CountMax;
        slot_count[hit] = CountMax;
        res.ready = 1'b1;
        res.status = STAT_SATURATED;
      end else begin
        cur = cur + 1;
        slot_count[hit] = cur;
        res.ready = 1'b1;
      end
    end else if (r.mode == MODE_CONSUME) begin
      if (hit < 0) begin
        res.status = STAT_EMPTY;
      end else begin
        cur = cur - 1;
        slot_count[hit] = cur;
        if (cur == 0) slot_live[hit] = 1'b0;
        res.ready = 1'b1;
      end
    end else begin
      if (hit < 0) res.status = STAT_EMPTY;
      else res.ready = 1'b1;
    end
    res.count = cur[15:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 22);
    if (r < 97) return $urandom_range(23, 60);
    return $urandom_range(100, 300);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Driver: one request beat at a time, taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_start <= 1'b0;
    end else begin
      if (req_start && !blk_busy) begin
        predicted_outcomes.push_back(apply_request(active_req));
      end
      if (!req_start || !blk_busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_start <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          active_req = request_backlog.pop_front();
          mode_i <= active_req.mode;
          src_endpoint_i <= active_req.key.src;
          dst_endpoint_i <= active_req.key.dst;
          sync_number_i <= active_req.key.sync_id;
          peer_npu_i <= active_req.key.peer;
          use_mask_i <= active_req.use_mask;
          npu_select_mask_i <= active_req.sel_bits;
          req_start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          req_start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done pulse carries one result beat.
  always @(posedge clk_i) begin
    sem_result_t want;
    if (rst_ni && done_o) begin
      outcomes_seen++;
      if (predicted_outcomes.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = predicted_outcomes.pop_front();
        if (ready_res_o !== want.ready)
          report_mismatch($sformatf("ready_res %b, want %b", ready_res_o, want.ready));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (count_after_o !== want.count)
          report_mismatch($sformatf("count_after %0d, want %0d", count_after_o, want.count));
      end
    end
  end

  function automatic sem_key_t random_key();
    sem_key_t k;
    k.src = 8'($urandom_range(0, 255));
    k.dst = 8'($urandom_range(0, 255));
    k.sync_id = 8'($urandom_range(0, 255));
    k.peer = 4'($urandom_range(0, 15));
    return k;
  endfunction

  function automatic sem_key_t near_key(input sem_key_t base);
    sem_key_t k;
    k = base ^ (28'd1 << $urandom_range(0, 27));
    return k;
  endfunction

  function automatic sem_req_t make_req(input logic [1:0] mode, input sem_key_t key,
                                        input logic use_mask, input logic [31:0] sel_bits);
    sem_req_t r;
    r.mode = mode;
    r.key = key;
    r.use_mask = use_mask;
    r.sel_bits = sel_bits;
    return r;
  endfunction

  task automatic queue_req(input logic [1:0] mode, input sem_key_t key,
                           input logic use_mask = 1'b0, input logic [31:0] sel_bits = '0);
    request_backlog.push_back(make_req(mode, key, use_mask, sel_bits));
    requests_issued++;
  endtask

  task automatic wait_idle();
    while (outcomes_seen != requests_issued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_npu_id(input logic [4:0] value);
    @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    own_npu_id = value;
  endtask

  task automatic refresh_pool(input int replace);
    int i;
    int idx;
    for (i = 0; i < replace; i++) begin
      idx = $urandom_range(0, PoolSize - 1);
      if ($urandom_range(0, 1) == 0) key_pool[idx] = random_key();
      else key_pool[idx] = near_key(key_pool[$urandom_range(0, PoolSize - 1)]);
    end
  endtask

  task automatic random_phase(input int beats, input int sig_pct, input int cons_pct,
                              input int wild_pct);
    int i;
    int pick;
    logic [1:0] mode;
    sem_key_t key;
    logic use_mask;
    logic [31:0] sel_bits;
    for (i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < sig_pct) mode = MODE_SIGNAL;
      else if (pick < sig_pct + cons_pct) mode = MODE_CONSUME;
      else mode = ($urandom_range(0, 3) == 0) ? ModeSpare : ModeQuery;
      pick = $urandom_range(0, 99);
      if (pick < wild_pct) key = random_key();
      else if (pick < wild_pct + 10) key = near_key(key_pool[$urandom_range(0, PoolSize - 1)]);
      else key = key_pool[$urandom_range(0, PoolSize - 1)];
      use_mask = ($urandom_range(0, 99) < 30);
      case ($urandom_range(0, 9))
        0: sel_bits = '0;
        1: sel_bits = '1;
        default: sel_bits = $urandom;
      endcase
      queue_req(mode, key, use_mask, sel_bits);
    end
  endtask

  initial begin
    sem_key_t key_a;
    sem_key_t key_z;
    int i;
    key_a = '1;
    key_z = '0;
    key_pool[0] = key_a;
    for (i = 1; i < 16; i++) begin
      key_pool[i].src = 8'(i * 17);
      key_pool[i].dst = 8'hA5 ^ 8'(i);
      key_pool[i].sync_id = 8'(i);
      key_pool[i].peer = 4'(i);
    end
    for (i = 16; i < PoolSize; i++) key_pool[i] = random_key();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_npu_id(5'd31);

    queue_req(ModeQuery, key_a);
    queue_req(MODE_CONSUME, key_a);
    queue_req(ModeSpare, key_a);
    queue_req(MODE_SIGNAL, key_a);
    queue_req(MODE_SIGNAL, key_a);
    queue_req(ModeSpare, key_a);
    queue_req(MODE_CONSUME, key_a);
    queue_req(MODE_CONSUME, key_a);
    queue_req(ModeQuery, key_a);
    queue_req(MODE_SIGNAL, key_a, 1'b1, 32'h7FFF_FFFF);
    queue_req(MODE_SIGNAL, key_a, 1'b0, 32'h0000_0000);
    queue_req(MODE_CONSUME, key_a, 1'b1, 32'h8000_0000);
    queue_req(MODE_SIGNAL, key_a);
    queue_req(ModeQuery, key_a, 1'b1, 32'h0000_0000);
    wait_idle();

    // Stack several tokens on one key with the requests back to back.
    steady_flow = 1'b1;
    for (i = 0; i < 6; i++) queue_req(MODE_SIGNAL, key_z);
    queue_req(MODE_CONSUME, key_z);
    queue_req(MODE_SIGNAL, key_z);
    queue_req(ModeQuery, key_z);
    wait_idle();
    steady_flow = 1'b0;

    // Fill every slot, overflow the table, then free one slot and reuse it.
    for (i = 1; i < 16; i++) queue_req(MODE_SIGNAL, key_pool[i]);
    queue_req(MODE_CONSUME, key_pool[3]);
    queue_req(MODE_SIGNAL, key_pool[15]);
    queue_req(ModeQuery, key_pool[15]);
    wait_idle();

    random_phase(100, 55, 25, 10);
    wait_idle();

    write_npu_id(5'd0);
    random_phase(100, 25, 50, 10);
    wait_idle();

    write_npu_id(5'($urandom_range(1, 30)));
    refresh_pool(6);
    steady_flow = 1'b1;
    random_phase(100, 40, 35, 15);
    wait_idle();
    steady_flow = 1'b0;

    write_npu_id(5'($urandom_range(0, 31)));
    refresh_pool(6);
    random_phase(100, 45, 30, 20);
    wait_idle();

    repeat (SettleCycles) @(posedge clk_i);
    if (predicted_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #LimitNs;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
